// ----- rtl/core/ttrle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttrle_pkg
// Types and constants of the timing table run-length encoder.
// ----------------------------------------------------------------------------
package ttrle_pkg;

    localparam int VALUE_BITS    = 32;
    localparam int NUM_SLOTS     = 4;
    localparam int SLOT_IDX_BITS = $clog2(NUM_SLOTS);

    // Run splits so the count never overflows
    localparam logic [VALUE_BITS-1:0] DELTA_SPLIT  = 32'hFFFF_FFFE;
    localparam logic [VALUE_BITS-1:0] OFFSET_SPLIT = 32'hFFFF_FFFF;

    // table_select codes
    localparam logic TABLE_DECODE = 1'b0;
    localparam logic TABLE_OFFSET = 1'b1;

    // Result slot positions, in output order
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_DEC_CLOSED = 2'd0;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_DEC_FINAL  = 2'd1;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_OFF_CLOSED = 2'd2;
    localparam logic [SLOT_IDX_BITS-1:0] SLOT_OFF_FINAL  = 2'd3;

    typedef struct packed {
        logic                  table_select;
        logic [VALUE_BITS-1:0] run_length;
        logic [VALUE_BITS-1:0] entry_value;
        logic                  last_of_run;
    } result_t;

endpackage

// ----- rtl/core/timing_table_run_length_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timing_table_run_length_encoder_core
// Run-length encodes per-sample decode deltas and composition offsets into
// decode table and composition offset table entries.
// ----------------------------------------------------------------------------
// Samples enter in decode order, one transaction per sample, and the core
// accepts one sample every clock cycle as long as it has no entries waiting.
// A sample that closes runs produces up to four entries (closed decode run,
// final decode run, closed offset run, final offset run), loaded together
// into a four-slot result register and drained one entry per cycle on the
// m_ channel while m_ready is high. While entries wait, s_ready stays low,
// except in the cycle the last waiting entry is taken. The last entry of
// each sample carries m_last_of_run. After the sample flagged s_last_sample
// all run state returns to reset, so a new track may follow directly.
// cfg_data sets offset_table_enable (reset 1); write it only while the core
// is idle.
module timing_table_run_length_encoder_core #(
    parameter int TIME_BITS = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,

    // sample input
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_BITS-1:0] s_decode_time,
    input  logic [TIME_BITS-1:0] s_compose_time,
    input  logic                 s_last_sample,

    // table entry output
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_table_select,
    output logic [31:0]          m_run_length,
    output logic signed [31:0]   m_entry_value,
    output logic                 m_last_of_run
);

    localparam int VB = ttrle_pkg::VALUE_BITS;
    localparam int NS = ttrle_pkg::NUM_SLOTS;
    localparam int IB = ttrle_pkg::SLOT_IDX_BITS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic          offset_enable_reg;

    // Run state. Only the low 32 bits of the previous decode time matter:
    // the delta is the low 32 bits of a wrapped difference.
    logic          seen_first_reg,       seen_first_next;
    logic [VB-1:0] prev_decode_reg,      prev_decode_next;
    logic [VB-1:0] current_delta_reg,    current_delta_next;
    logic [VB-1:0] delta_run_count_reg,  delta_run_count_next;
    logic [VB-1:0] current_offset_reg,   current_offset_next;
    logic [VB-1:0] offset_run_count_reg, offset_run_count_next;

    // Result slots, drained lowest index first
    ttrle_pkg::result_t slot_reg [NS];
    ttrle_pkg::result_t slot_next [NS];
    logic [NS-1:0]      slot_valid_reg, slot_valid_next;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic          in_xfer;
    logic          out_xfer;
    logic [IB-1:0] head_idx;
    logic [NS-1:0] valid_after_pop;

    assign cfg_ready = 1'b1;
    assign m_valid   = |slot_valid_reg;
    assign out_xfer  = m_valid && m_ready;
    // Accept when no entry waits, or the only one waiting leaves now
    assign s_ready   = (slot_valid_reg == '0) || ($onehot(slot_valid_reg) && m_ready);
    assign in_xfer   = s_valid && s_ready;

    always_comb begin
        head_idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (slot_valid_reg[i]) begin
                head_idx = IB'(i);
            end
        end
    end

    always_comb begin
        valid_after_pop = slot_valid_reg;
        if (out_xfer) begin
            valid_after_pop[head_idx] = 1'b0;
        end
    end

    assign m_table_select = slot_reg[head_idx].table_select;
    assign m_run_length   = slot_reg[head_idx].run_length;
    assign m_entry_value  = $signed(slot_reg[head_idx].entry_value);
    assign m_last_of_run  = slot_reg[head_idx].last_of_run;

    // ------------------------------------------------------------------
    // Per-sample run update
    // ------------------------------------------------------------------
    logic [VB-1:0] delta;
    logic [VB-1:0] offset;
    logic [NS-1:0] new_valid;

    assign delta  = s_decode_time[VB-1:0] - prev_decode_reg;
    assign offset = s_compose_time[VB-1:0] - s_decode_time[VB-1:0];

    always_comb begin
        seen_first_next       = seen_first_reg;
        prev_decode_next      = prev_decode_reg;
        current_delta_next    = current_delta_reg;
        delta_run_count_next  = delta_run_count_reg;
        current_offset_next   = current_offset_reg;
        offset_run_count_next = offset_run_count_reg;
        new_valid             = '0;
        for (int i = 0; i < NS; i++) begin
            slot_next[i] = slot_reg[i];
        end

        // decode table
        if (!seen_first_reg) begin
            seen_first_next  = 1'b1;
            prev_decode_next = s_decode_time[VB-1:0];
        end else begin
            prev_decode_next = s_decode_time[VB-1:0];
            if (delta_run_count_reg == '0) begin
                current_delta_next   = delta;
                delta_run_count_next = VB'(1);
            end else if (delta != current_delta_reg ||
                         delta_run_count_reg >= ttrle_pkg::DELTA_SPLIT) begin
                new_valid[ttrle_pkg::SLOT_DEC_CLOSED] = 1'b1;
                slot_next[ttrle_pkg::SLOT_DEC_CLOSED].table_select = ttrle_pkg::TABLE_DECODE;
                slot_next[ttrle_pkg::SLOT_DEC_CLOSED].run_length   = delta_run_count_reg;
                slot_next[ttrle_pkg::SLOT_DEC_CLOSED].entry_value  = current_delta_reg;
                current_delta_next   = delta;
                delta_run_count_next = VB'(1);
            end else begin
                delta_run_count_next = delta_run_count_reg + VB'(1);
            end
        end
        if (s_last_sample) begin
            new_valid[ttrle_pkg::SLOT_DEC_FINAL] = 1'b1;
            slot_next[ttrle_pkg::SLOT_DEC_FINAL].table_select = ttrle_pkg::TABLE_DECODE;
            if (delta_run_count_next == '0) begin
                // single-sample track
                slot_next[ttrle_pkg::SLOT_DEC_FINAL].run_length  = VB'(1);
                slot_next[ttrle_pkg::SLOT_DEC_FINAL].entry_value = '0;
            end else begin
                slot_next[ttrle_pkg::SLOT_DEC_FINAL].run_length  =
                    delta_run_count_next + VB'(1);
                slot_next[ttrle_pkg::SLOT_DEC_FINAL].entry_value = current_delta_next;
            end
        end

        // composition offset table
        if (offset_enable_reg) begin
            if (offset_run_count_reg == '0) begin
                current_offset_next   = offset;
                offset_run_count_next = VB'(1);
            end else if (offset != current_offset_reg ||
                         offset_run_count_reg >= ttrle_pkg::OFFSET_SPLIT) begin
                new_valid[ttrle_pkg::SLOT_OFF_CLOSED] = 1'b1;
                slot_next[ttrle_pkg::SLOT_OFF_CLOSED].table_select = ttrle_pkg::TABLE_OFFSET;
                slot_next[ttrle_pkg::SLOT_OFF_CLOSED].run_length   = offset_run_count_reg;
                slot_next[ttrle_pkg::SLOT_OFF_CLOSED].entry_value  = current_offset_reg;
                current_offset_next   = offset;
                offset_run_count_next = VB'(1);
            end else begin
                offset_run_count_next = offset_run_count_reg + VB'(1);
            end
            if (s_last_sample) begin
                new_valid[ttrle_pkg::SLOT_OFF_FINAL] = 1'b1;
                slot_next[ttrle_pkg::SLOT_OFF_FINAL].table_select = ttrle_pkg::TABLE_OFFSET;
                slot_next[ttrle_pkg::SLOT_OFF_FINAL].run_length   = offset_run_count_next;
                slot_next[ttrle_pkg::SLOT_OFF_FINAL].entry_value  = current_offset_next;
            end
        end

        // highest loaded slot closes the sample's burst
        for (int i = 0; i < NS; i++) begin
            slot_next[i].last_of_run = new_valid[i] && ((new_valid >> (i + 1)) == '0);
        end

        // end of track: back to reset
        if (s_last_sample) begin
            seen_first_next       = 1'b0;
            prev_decode_next      = '0;
            current_delta_next    = '0;
            delta_run_count_next  = '0;
            current_offset_next   = '0;
            offset_run_count_next = '0;
        end
    end

    assign slot_valid_next = in_xfer ? new_valid : valid_after_pop;

    // ------------------------------------------------------------------
    // Clocked logic
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_enable_reg    <= 1'b1;
            seen_first_reg       <= 1'b0;
            prev_decode_reg      <= '0;
            current_delta_reg    <= '0;
            delta_run_count_reg  <= '0;
            current_offset_reg   <= '0;
            offset_run_count_reg <= '0;
            slot_valid_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                offset_enable_reg <= cfg_data;
            end
            if (in_xfer) begin
                seen_first_reg       <= seen_first_next;
                prev_decode_reg      <= prev_decode_next;
                current_delta_reg    <= current_delta_next;
                delta_run_count_reg  <= delta_run_count_next;
                current_offset_reg   <= current_offset_next;
                offset_run_count_reg <= offset_run_count_next;
            end
            slot_valid_reg <= slot_valid_next;
        end
    end

    // slot payload, no reset
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            for (int i = 0; i < NS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // no entry waiting means the input side is open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with no entry pending");

    // end of track always yields a decode entry
    a_last_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_last_sample) |=> m_valid)
        else $error("last sample produced no entry");

    // end of track clears run state
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_last_sample) |=>
            (!seen_first_reg && delta_run_count_reg == '0 && offset_run_count_reg == '0))
        else $error("run state not cleared after last sample");

    // decode count stays at or below the split so the final +1 cannot wrap
    a_delta_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        delta_run_count_reg <= ttrle_pkg::DELTA_SPLIT)
        else $error("decode run count past split");

    // burst end is flagged on exactly one loaded slot
    a_one_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && s_last_sample) |=>
            $onehot({slot_reg[3].last_of_run && slot_valid_reg[3],
                     slot_reg[2].last_of_run && slot_valid_reg[2],
                     slot_reg[1].last_of_run && slot_valid_reg[1],
                     slot_reg[0].last_of_run && slot_valid_reg[0]}))
        else $error("burst end flag not unique");

endmodule
